### src/apse_pkg.sv
// ============================================================================
// apse_pkg
// Shared types and constants of the Annex-B parameter-set extractor.
// ============================================================================
`default_nettype none

package apse_pkg;

    // Parse phase of the byte scanner.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEARCH,
        PH_HEADER,
        PH_BODY
    } t_phase;

    localparam logic       MODE_FEED       = 1'b0;
    localparam logic       MODE_READ       = 1'b1;
    localparam logic       STORE_SPS       = 1'b0;
    localparam logic       STORE_PPS       = 1'b1;
    localparam logic [4:0] NAL_TYPE_MASK   = 5'h1F;
    localparam logic [4:0] NAL_SPS         = 5'd7;
    localparam logic [4:0] NAL_PPS         = 5'd8;
    localparam logic [7:0] START_CODE_BYTE = 8'h01;
    localparam logic [7:0] ZERO_BYTE       = 8'h00;

    // Up to three store bytes are confirmed by one packet byte.
    localparam int KEEP_SLOTS = 3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       packet_last;
        logic       packet_keyframe;
        logic       read_which;
        logic [5:0] read_index;
    } t_item;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_keep;

endpackage

`default_nettype wire

### src/apse_ram.sv
// ============================================================================
// apse_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module apse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/apse_parser.sv
// ============================================================================
// apse_parser
// Start-code scanner and unit tracker: phase, byte window, unit count,
// committed lengths and flags, plus the store bytes confirmed per item.
// ============================================================================
`default_nettype none

module apse_parser #(
    parameter int STORE_BYTES = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_advance,
    input  wire apse_pkg::t_item                    i_item,
    output apse_pkg::t_keep [apse_pkg::KEEP_SLOTS-1:0] o_keep,
    output logic [$clog2(STORE_BYTES+1)-1:0]        o_keep_base,
    output logic                                    o_keep_sel,
    output logic [$clog2(STORE_BYTES+1)-1:0]        o_sps_len,
    output logic [$clog2(STORE_BYTES+1)-1:0]        o_pps_len,
    output logic                                    o_cached,
    output logic                                    o_overflow
);

    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam logic [CW:0] STORE_LIMIT = (CW+1)'(STORE_BYTES);

    apse_pkg::t_phase r_phase, n_phase, w_phase;
    logic             r_parse_on, n_parse_on, w_on;
    logic [23:0]      r_recent, n_recent, w_recent;
    logic [1:0]       r_region, n_region, w_region;
    logic [4:0]       r_type, n_type, w_type, w_hdr_type;
    logic [CW-1:0]    r_count, n_count, w_base, w_count_new;
    logic [CW-1:0]    r_sps_len, n_sps_len, w_sps_end;
    logic [CW-1:0]    r_pps_len, n_pps_len, w_pps_end;
    logic             r_cached, n_cached;
    logic             r_overflow, n_overflow;

    logic       w_feed, w_first, w_code, w_term, w_is_ps, w_end, w_keep_ovf;
    logic [7:0] w_b;
    apse_pkg::t_keep [apse_pkg::KEEP_SLOTS-1:0] w_raw, w_cmp, w_keep;

    assign w_b     = i_item.data_byte;
    assign w_feed  = i_advance && (i_item.mode == apse_pkg::MODE_FEED);
    assign w_first = (r_phase == apse_pkg::PH_IDLE);

    // The first byte of a packet opens a scan with a clean window.
    assign w_phase  = w_first ? apse_pkg::PH_SEARCH : r_phase;
    assign w_on     = w_first ? (i_item.packet_keyframe && !r_cached) : r_parse_on;
    assign w_recent = w_first ? 24'h0 : r_recent;
    assign w_region = w_first ? 2'd0 : r_region;

    assign w_code = (w_region == 2'd3) && (w_recent == 24'h0)
                    && (w_b == apse_pkg::START_CODE_BYTE);
    assign w_term = (w_region >= 2'd2) && (w_recent[15:0] == 16'h0)
                    && (w_b[7:1] == apse_pkg::ZERO_BYTE[7:1]);

    assign w_hdr_type = w_b[4:0] & apse_pkg::NAL_TYPE_MASK;
    assign w_type     = (w_phase == apse_pkg::PH_HEADER) ? w_hdr_type : r_type;
    assign w_is_ps    = (w_type == apse_pkg::NAL_SPS) || (w_type == apse_pkg::NAL_PPS);
    assign w_base     = (w_phase == apse_pkg::PH_HEADER) ? '0 : r_count;

    assign w_end = w_on && (((w_phase == apse_pkg::PH_HEADER) && i_item.packet_last)
                 || ((w_phase == apse_pkg::PH_BODY) && (w_term || i_item.packet_last)));

    // Store bytes confirmed by this item, packed in order, and their effect on the count.
    always_comb begin
        logic [1:0]  k;
        logic [1:0]  n;
        logic [CW:0] a;
        logic [CW:0] sum;
        w_raw = '0;
        w_cmp = '0;
        w_keep = '0;
        w_keep_ovf = 1'b0;
        k = 2'd0;
        if (w_feed && w_on) begin
            case (w_phase)
                apse_pkg::PH_HEADER: begin
                    w_raw[2] = '{vld: 1'b1, data: w_b};
                end
                apse_pkg::PH_BODY: begin
                    if (!w_term) begin
                        w_raw[0] = '{vld: (w_region >= 2'd2), data: w_recent[15:8]};
                        w_raw[1] = '{vld: i_item.packet_last && (w_region >= 2'd1),
                                     data: w_recent[7:0]};
                        w_raw[2] = '{vld: i_item.packet_last, data: w_b};
                    end
                end
                default: ;
            endcase
        end
        for (int i = 0; i < apse_pkg::KEEP_SLOTS; i++) begin
            if (w_raw[i].vld) begin
                w_cmp[k] = w_raw[i];
                k = k + 2'd1;
            end
        end
        n = k;
        for (int i = 0; i < apse_pkg::KEEP_SLOTS; i++) begin
            a = (CW+1)'(w_base) + (CW+1)'(i);
            if (w_cmp[i].vld && w_is_ps) begin
                if (a < STORE_LIMIT) begin
                    w_keep[i] = w_cmp[i];
                end else begin
                    w_keep_ovf = 1'b1;
                end
            end
        end
        sum = (CW+1)'(w_base) + (CW+1)'(n);
        if (!w_is_ps) begin
            w_count_new = w_base;
        end else if (sum > STORE_LIMIT) begin
            w_count_new = CW'(STORE_BYTES);
        end else begin
            w_count_new = sum[CW-1:0];
        end
    end

    assign w_sps_end = (w_type == apse_pkg::NAL_SPS) ? w_count_new : r_sps_len;
    assign w_pps_end = (w_type == apse_pkg::NAL_PPS) ? w_count_new : r_pps_len;

    always_comb begin
        n_phase    = r_phase;
        n_parse_on = r_parse_on;
        n_recent   = r_recent;
        n_region   = r_region;
        n_type     = r_type;
        n_count    = r_count;
        n_sps_len  = r_sps_len;
        n_pps_len  = r_pps_len;
        n_cached   = r_cached;
        n_overflow = r_overflow;
        if (w_feed) begin
            n_phase    = w_phase;
            n_parse_on = w_on;
            n_recent   = w_recent;
            n_region   = w_region;
            if (w_on) begin
                unique case (w_phase)
                    apse_pkg::PH_SEARCH: begin
                        if (w_code) begin
                            n_phase = apse_pkg::PH_HEADER;
                        end else begin
                            n_recent = {w_recent[15:0], w_b};
                            if (w_region != 2'd3) begin
                                n_region = w_region + 2'd1;
                            end
                        end
                    end
                    apse_pkg::PH_HEADER: begin
                        n_type   = w_hdr_type;
                        n_count  = w_count_new;
                        n_recent = 24'h0;
                        n_region = 2'd0;
                        n_phase  = apse_pkg::PH_BODY;
                    end
                    apse_pkg::PH_BODY: begin
                        if (w_term) begin
                            // Rescan from the terminator's first byte.
                            n_recent = {16'h0, w_b};
                            n_region = 2'd3;
                            n_phase  = apse_pkg::PH_SEARCH;
                        end else begin
                            n_recent = {8'h0, w_recent[7:0], w_b};
                            if (w_region < 2'd2) begin
                                n_region = w_region + 2'd1;
                            end
                            n_count = w_count_new;
                        end
                    end
                    default: ;
                endcase
                if (w_keep_ovf) begin
                    n_overflow = 1'b1;
                end
                if (w_end) begin
                    n_sps_len = w_sps_end;
                    n_pps_len = w_pps_end;
                    if ((w_sps_end != '0) && (w_pps_end != '0)) begin
                        n_cached   = 1'b1;
                        n_parse_on = 1'b0;
                    end
                end
            end
            if (i_item.packet_last) begin
                n_phase    = apse_pkg::PH_IDLE;
                n_parse_on = 1'b0;
                n_recent   = 24'h0;
                n_region   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= apse_pkg::PH_IDLE;
            r_parse_on <= 1'b0;
            r_recent   <= 24'h0;
            r_region   <= 2'd0;
            r_type     <= 5'd0;
            r_count    <= '0;
            r_sps_len  <= '0;
            r_pps_len  <= '0;
            r_cached   <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_parse_on <= n_parse_on;
            r_recent   <= n_recent;
            r_region   <= n_region;
            r_type     <= n_type;
            r_count    <= n_count;
            r_sps_len  <= n_sps_len;
            r_pps_len  <= n_pps_len;
            r_cached   <= n_cached;
            r_overflow <= n_overflow;
        end
    end

    assign o_keep      = w_keep;
    assign o_keep_base = w_base;
    assign o_keep_sel  = (w_type == apse_pkg::NAL_PPS) ? apse_pkg::STORE_PPS
                                                       : apse_pkg::STORE_SPS;
    assign o_sps_len   = r_sps_len;
    assign o_pps_len   = r_pps_len;
    assign o_cached    = r_cached;
    assign o_overflow  = r_overflow;

endmodule

`default_nettype wire

### src/apse_store.sv
// ============================================================================
// apse_store
// Both parameter-set stores in four byte banks interleaved by address, so
// that three consecutive bytes can be written in one cycle.
// ============================================================================
`default_nettype none

module apse_store #(
    parameter int STORE_BYTES = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_advance,
    input  wire apse_pkg::t_keep [apse_pkg::KEEP_SLOTS-1:0] i_keep,
    input  wire logic [$clog2(STORE_BYTES+1)-1:0]      i_keep_base,
    input  wire logic                                  i_keep_sel,
    input  wire logic                                  i_rd_hit,
    input  wire logic                                  i_rd_which,
    input  wire logic [5:0]                            i_rd_index,
    output logic      [7:0]                            o_read_byte
);

    localparam int CW         = $clog2(STORE_BYTES + 1);
    localparam int IW         = (CW > 6) ? CW : 6;
    localparam int ROWS       = (STORE_BYTES + 3) / 4;
    localparam int RRW        = $clog2(ROWS);
    localparam int BANK_DEPTH = 2 << RRW;

    logic [IW-1:0]  w_idx;
    logic [RRW-1:0] w_rd_row;
    logic [7:0]     w_bank_q [4];
    logic [1:0]     r_rd_bank;
    logic           r_rd_hit;

    assign w_idx    = IW'(i_rd_index);
    assign w_rd_row = RRW'(w_idx >> 2);

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic           w_we;
        logic [RRW:0]   w_waddr;
        logic [7:0]     w_wdata;

        // Consecutive addresses land in distinct banks, so at most one slot matches.
        always_comb begin
            logic [CW:0] a;
            w_we    = 1'b0;
            w_waddr = '0;
            w_wdata = '0;
            for (int i = 0; i < apse_pkg::KEEP_SLOTS; i++) begin
                a = (CW+1)'(i_keep_base) + (CW+1)'(i);
                if (i_keep[i].vld && (a[1:0] == 2'(j))) begin
                    w_we    = i_advance;
                    w_waddr = {i_keep_sel, RRW'(a >> 2)};
                    w_wdata = i_keep[i].data;
                end
            end
        end

        apse_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_re    (i_advance),
            .i_raddr ({i_rd_which, w_rd_row}),
            .o_rdata (w_bank_q[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_rd_bank <= i_rd_index[1:0];
            r_rd_hit  <= i_rd_hit;
        end
    end

    assign o_read_byte = r_rd_hit ? w_bank_q[r_rd_bank] : apse_pkg::ZERO_BYTE;

endmodule

`default_nettype wire

### src/annexb_parameter_set_extractor.sv
// ============================================================================
// annexb_parameter_set_extractor
// Scans keyframe Annex-B packets for SPS and PPS units, caches them and
// returns stored bytes on request.
// ============================================================================
//
//  Channel   Direction  Payload                                   Handshake
//  s_axis    in         tdata: byte/keyframe/which/index,         tvalid/tready
//                       tuser: mode, tlast: packet end
//  m_axis    out        tdata: read byte, lengths, flags          tvalid/tready
//
// One request is taken per cycle while m_axis is not stalled; its result is
// valid on m_axis once it has passed the input register, then the result
// and RAM read registers.
// The per-byte scan, unit tracking and store writes are a single pass of
// logic between the input register and the state and bank RAMs.
// Reset clears all scan state, lengths and flags; store contents are not
// cleared, and bytes beyond a committed length read as zero.
// A stall on m_axis holds the whole pipeline; one request waits in the
// input register meanwhile.
// ============================================================================
`default_nettype none

module annexb_parameter_set_extractor #(
    parameter int STORE_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] data_byte, [8] packet_keyframe, [9] read_which, [15:10] read_index
    input  wire logic [15:0] s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_byte, [14:8] sps_length, [21:15] pps_length,
    // [22] both_cached, [23] overflow
    output logic [23:0]      m_axis_tdata
);

    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int IW = (CW > 6) ? CW : 6;

    apse_pkg::t_item r_in;
    logic            r_in_valid, n_in_valid;
    logic            r_out_valid, n_out_valid;
    logic            w_advance, w_s_accept, w_rd_hit;

    apse_pkg::t_keep [apse_pkg::KEEP_SLOTS-1:0] w_keep;
    logic [CW-1:0]   w_keep_base, w_sps_len, w_pps_len, w_rd_len;
    logic            w_keep_sel, w_cached, w_overflow;
    logic [7:0]      w_read_byte;
    logic [CW+6:0]   w_sps_ext, w_pps_ext;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_s_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in.mode            <= s_axis_tuser[0];
            r_in.data_byte       <= s_axis_tdata[7:0];
            r_in.packet_last     <= s_axis_tlast;
            r_in.packet_keyframe <= s_axis_tdata[8];
            r_in.read_which      <= s_axis_tdata[9];
            r_in.read_index      <= s_axis_tdata[15:10];
        end
    end

    apse_parser #(
        .STORE_BYTES (STORE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_item      (r_in),
        .o_keep      (w_keep),
        .o_keep_base (w_keep_base),
        .o_keep_sel  (w_keep_sel),
        .o_sps_len   (w_sps_len),
        .o_pps_len   (w_pps_len),
        .o_cached    (w_cached),
        .o_overflow  (w_overflow)
    );

    // A read request leaves the lengths untouched, so the current ones apply.
    assign w_rd_len = (r_in.read_which == apse_pkg::STORE_PPS) ? w_pps_len : w_sps_len;
    assign w_rd_hit = (r_in.mode == apse_pkg::MODE_READ)
                      && (IW'(r_in.read_index) < IW'(w_rd_len));

    apse_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk       (i_clk),
        .i_advance   (w_advance),
        .i_keep      (w_keep),
        .i_keep_base (w_keep_base),
        .i_keep_sel  (w_keep_sel),
        .i_rd_hit    (w_rd_hit),
        .i_rd_which  (r_in.read_which),
        .i_rd_index  (r_in.read_index),
        .o_read_byte (w_read_byte)
    );

    // The parser state changes only with an advance, so after that edge it
    // already holds the result of the request now in the output stage.
    assign w_sps_ext = {7'b0, w_sps_len};
    assign w_pps_ext = {7'b0, w_pps_len};

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {w_overflow, w_cached, w_pps_ext[6:0], w_sps_ext[6:0],
                            w_read_byte};

    a_cached_lengths : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cached |-> ((w_sps_len != '0) && (w_pps_len != '0)))
        else $error("both_cached set without two committed lengths");

    a_cached_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cached |=> w_cached)
        else $error("both_cached dropped");

    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sps_len <= CW'(STORE_BYTES)) && (w_pps_len <= CW'(STORE_BYTES)))
        else $error("committed length beyond store capacity");

    a_out_from_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance))
        else $error("result shown without a processed request");

endmodule

`default_nettype wire
